>>> rtl/smf_pkg.sv
package smf_pkg;

    localparam int PAT_MAX = 32;
    localparam int IDX_W   = $clog2(PAT_MAX);
    localparam int LEN_W   = 6;
    localparam int POS_W   = 31;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 6;

    localparam logic [POS_W-1:0] COUNT_MAX = {POS_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TEXT  = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        CFG_LENGTH      = 1'b0,
        CFG_IGNORE_CASE = 1'b1
    } cfg_idx_t;

    // control bundle broadcast to every cell of the window
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [IDX_W-1:0]  load_idx;
        logic [BYTE_W-1:0] lower;
        logic [BYTE_W-1:0] upper;
        logic [BYTE_W-1:0] text;
        logic [IDX_W-1:0]  ins_pos;
        logic [LEN_W-1:0]  len;
        logic              ignore_case;
    } smf_ctl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_pos;
    } smf_res_t;

endpackage

>>> rtl/smf_if.sv
interface smf_req_if;
    import smf_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [4:0]        pattern_index;
    logic [7:0]        lower_byte;
    logic [7:0]        upper_byte;
    logic [30:0]       start_pos;
    logic [7:0]        text_byte;
    logic              last_byte;

    modport source (output valid, op, pattern_index, lower_byte, upper_byte, start_pos,
                    text_byte, last_byte, input ready);
    modport sink   (input valid, op, pattern_index, lower_byte, upper_byte, start_pos,
                    text_byte, last_byte, output ready);
endinterface

interface smf_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [30:0] match_pos;

    modport source (output valid, found, match_pos, input ready);
    modport sink   (input valid, found, match_pos, output ready);
endinterface

>>> rtl/case_folding_substring_matcher_top.sv
// Path: a text transaction that ends the search shows its result on rsp once it has
//   passed the window cells, then the decision stage, then the result queue.
// Throughput: one transaction per cycle; req.ready drops only while the two-entry
//   result queue, counting a text byte still in the decision stage, is full.
// Reset: counters, search state and configuration clear at once (length 1, case folding
//   off, search idle); the pattern store holds no reset value and must be loaded.
module case_folding_substring_matcher_top
    import smf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    smf_req_if.sink          req,
    smf_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // configuration
    logic [LEN_W-1:0] len_cfg_reg;
    logic             ign_cfg_reg;
    logic [LEN_W-1:0] len_eff;

    // window chain
    smf_ctl_t          ctl;
    logic [BYTE_W-1:0] win [PAT_MAX];
    logic [PAT_MAX-1:0] hits;

    // input side
    logic             accept;
    logic             acc_text;
    logic             acc_start;
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] cnt_next;
    logic             unsat;

    // first stage: a transaction passing to the decision stage
    logic             s1_txt_reg;
    logic             s1_start_reg;
    logic             s1_last_reg;
    logic             s1_unsat_reg;
    logic [POS_W-1:0] s1_seen_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic [POS_W-1:0] s1_min_reg;

    // decision stage
    logic             done_reg;
    logic             done_next;
    logic [POS_W-1:0] min_reg;
    logic [POS_W-1:0] min_next;
    logic [POS_W-1:0] s1_len_ext;
    logic [POS_W-1:0] start_ofs;
    logic             eligible;
    logic             all_hit;
    logic             push;
    smf_res_t         res;
    logic [1:0]       occ;

    // Configuration writes; only two registers, so every index hits one of them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_W'(1);
            ign_cfg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LENGTH:      len_cfg_reg <= cfg_wdata[LEN_W-1:0];
                CFG_IGNORE_CASE: ign_cfg_reg <= cfg_wdata[0];
                default:         ign_cfg_reg <= ign_cfg_reg;
            endcase
        end
    end

    // zero length acts as one, anything past the store depth is clipped
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_cfg_reg > LEN_W'(PAT_MAX))
        begin
            len_eff = LEN_W'(PAT_MAX);
        end
        else
        begin
            len_eff = len_cfg_reg;
        end
    end

    // Ready: room must remain for a result from the byte in the decision stage and
    // from the one accepted now.
    assign req.ready = ((occ + {1'b0, s1_txt_reg}) <= 2'd1);
    assign accept    = req.valid && req.ready;
    assign acc_text  = accept && (req.op == OP_TEXT);
    assign acc_start = accept && (req.op == OP_START);

    assign ctl.shift       = acc_text;
    assign ctl.load        = accept && (req.op == OP_LOAD);
    assign ctl.load_idx    = req.pattern_index;
    assign ctl.lower       = req.lower_byte;
    assign ctl.upper       = req.upper_byte;
    assign ctl.text        = req.text_byte;
    assign ctl.ins_pos     = IDX_W'(len_eff - LEN_W'(1));
    assign ctl.len         = len_eff;
    assign ctl.ignore_case = ign_cfg_reg;

    // Cell k holds pattern byte k and the text byte that must line up with it;
    // each cell registers its own compare against the shifted window.
    for (genvar k = 0; k < PAT_MAX; k++)
    begin : g_cell
        logic [BYTE_W-1:0] nbr;
        if (k == PAT_MAX - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = win[k+1];
        end

        smf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .pos      (IDX_W'(k)),
            .nbr_byte (nbr),
            .win_byte (win[k]),
            .hit      (hits[k])
        );
    end

    // Byte counter; bytes that follow a finished search still count, but a start
    // clears it before they could matter.
    assign unsat = (cnt_reg != COUNT_MAX);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc_start)
        begin
            cnt_next = '0;
        end
        else if (acc_text && unsat)
        begin
            cnt_next = cnt_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_txt_reg   <= 1'b0;
            s1_start_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_txt_reg   <= acc_text;
            s1_start_reg <= acc_start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= req.last_byte;
            s1_unsat_reg <= unsat;
            s1_seen_reg  <= cnt_reg + POS_W'(1);
            s1_len_reg   <= len_eff;
            s1_min_reg   <= req.start_pos;
        end
    end

    // Decision stage: a match needs the whole window, a start at or after the least
    // offset, and a counter that was not saturated.
    assign all_hit    = &hits;
    assign s1_len_ext = {{(POS_W-LEN_W){1'b0}}, s1_len_reg};
    assign start_ofs  = s1_seen_reg - s1_len_ext;
    assign eligible   = s1_unsat_reg && (s1_seen_reg >= s1_len_ext) && (start_ofs >= min_reg);

    always_comb
    begin
        push      = 1'b0;
        res       = '0;
        done_next = done_reg;
        min_next  = min_reg;
        if (s1_start_reg)
        begin
            done_next = 1'b0;
            min_next  = s1_min_reg;
        end
        else if (s1_txt_reg && !done_reg)
        begin
            if (eligible && all_hit)
            begin
                push          = 1'b1;
                res.found     = 1'b1;
                res.match_pos = start_ofs;
                done_next     = 1'b1;
            end
            else if (s1_last_reg)
            begin
                // text ended with no match: not-found result, position zero
                push      = 1'b1;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b1;
            min_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            min_reg  <= min_next;
        end
    end

    smf_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .occ       (occ),
        .rsp       (rsp)
    );

    // every result closes the search
    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> done_reg)
        else $error("search still active after a result");

    // a found match never starts before the least allowed offset
    a_min_start: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.found) |-> (res.match_pos >= min_reg))
        else $error("match reported before the least offset");

    // bytes after a finished search give nothing
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_txt_reg && done_reg) |-> !push)
        else $error("result from an idle search");

endmodule

>>> rtl/smf_cell.sv
module smf_cell
    import smf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  smf_ctl_t          ctl,
    input  logic [IDX_W-1:0]  pos,
    input  logic [BYTE_W-1:0] nbr_byte,
    output logic [BYTE_W-1:0] win_byte,
    output logic              hit
);

    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;
    logic [BYTE_W-1:0] lower_reg;
    logic [BYTE_W-1:0] upper_reg;
    logic              hit_reg;
    logic              hit_next;

    // the newest byte enters at the last pattern position, older bytes move down
    assign win_next = (pos == ctl.ins_pos) ? ctl.text : nbr_byte;

    always_comb
    begin
        if ({1'b0, pos} >= ctl.len)
        begin
            hit_next = 1'b1;
        end
        else
        begin
            hit_next = (win_next == lower_reg) ||
                       (ctl.ignore_case && (win_next == upper_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (ctl.shift)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            hit_reg <= hit_next;
        end
        if (ctl.load && (ctl.load_idx == pos))
        begin
            lower_reg <= ctl.lower;
            upper_reg <= ctl.upper;
        end
    end

    assign win_byte = win_reg;
    assign hit      = hit_reg;

endmodule

>>> rtl/smf_resq.sv
module smf_resq
    import smf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smf_res_t       push_data,
    output logic [1:0]     occ,
    smf_rsp_if.source      rsp
);

    smf_res_t   mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       pop;

    assign pop = rsp.valid && rsp.ready;

    always_comb
    begin
        occ_next = occ_reg;
        case ({push, pop})
            2'b10:   occ_next = occ_reg + 2'd1;
            2'b01:   occ_next = occ_reg - 2'd1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            occ_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign rsp.valid     = (occ_reg != 2'd0);
    assign rsp.found     = mem_reg[rd_reg].found;
    assign rsp.match_pos = mem_reg[rd_reg].match_pos;
    assign occ           = occ_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (occ_reg == 2'd2)))
        else $error("result queue overflow");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 2'd2)
        else $error("result queue count out of range");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (occ_reg == $past(occ_reg) - 2'd1))
        else $error("result queue count not decremented on pop");

endmodule

>>> test/tb_case_folding_substring_matcher_top.sv
module tb_case_folding_substring_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    // Run shape
    localparam int ITEMS        = 1650;  // random transactions after the directed table
    localparam int NUM_PHASES   = 8;     // one register setting per phase
    localparam int HOLD_CYCLES  = 150;   // long result back-pressure stretch
    localparam int DRAIN_CYCLES = 6;     // pipeline flush plus margin
    localparam int STALL_LIMIT  = 4000;  // cycles without any transaction

    // op code 3 has no meaning in the block and must be dropped
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [BYTE_W-1:0] LC_A = 8'h61;
    localparam logic [BYTE_W-1:0] UC_A = 8'h41;
    localparam logic [BYTE_W-1:0] LC_X = 8'h78;

    // How the expectation of one request is formed
    typedef enum logic [1:0] {
        CHK_MODEL,   // from the predictor
        CHK_QUIET,   // typed in: no result
        CHK_RESULT   // typed in: the result held in the row
    } chk_mode_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [4:0]        idx;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] up;
        logic [POS_W-1:0]  spos;
        logic [BYTE_W-1:0] txt;
        logic              fin;
    } req_t;

    typedef struct packed {
        chk_mode_t mode;
        smf_res_t  res;
    } chk_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        op;
        logic [4:0]        idx;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] up;
        logic [POS_W-1:0]  spos;
        logic [BYTE_W-1:0] txt;
        logic              fin;
        chk_mode_t         mode;
        logic              found;
        logic [POS_W-1:0]  pos;
    } dir_row_t;

    localparam chk_t BY_MODEL = '{CHK_MODEL, '0};

    // Directed table. A CFG row carries the pattern length in lo and the
    // case-folding bit in up[0]; it is applied once the block has drained.
    dir_row_t dir_rows [0:25] = '{
        // text while idle right after reset: dropped
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     UC_A,  1'b0, CHK_QUIET,  1'b0, 31'd0},
        // unused op code, every field bit set: dropped
        '{ROW_ITEM, OP_SPARE, 5'd31, 8'hFF, 8'hFF, COUNT_MAX, 8'hFF, 1'b1, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_LOAD,  5'd0,  LC_A,  UC_A,  31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_LOAD,  5'd31, 8'hFF, 8'h00, 31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_LOAD,  5'd1,  8'h00, 8'hFF, 31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        // length 1, folding off: the upper byte must not hit
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, 31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     UC_A,  1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b0, CHK_RESULT, 1'b1, 31'd1},
        // bytes after a hit are dropped, even a final one
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b1, CHK_QUIET,  1'b0, 31'd0},
        // offset at its maximum: nothing may hit, the final byte reports not found
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, COUNT_MAX, 8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b1, CHK_RESULT, 1'b0, 31'd0},
        // a hit completed by the final byte reports found
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, 31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b1, CHK_RESULT, 1'b1, 31'd1},
        // hit below the offset is skipped, the one exactly at it counts
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, 31'd2,     8'h00, 1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_X,  1'b0, CHK_QUIET,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b1, CHK_RESULT, 1'b1, 31'd2},
        // length 2 with folding: both positions hit through their upper bytes
        '{ROW_CFG,  OP_LOAD,  5'd0,  8'd2,  8'd1,  31'd0,     8'h00, 1'b0, CHK_MODEL,  1'b0, 31'd0},
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, 31'd0,     8'h00, 1'b0, CHK_MODEL,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     UC_A,  1'b0, CHK_MODEL,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     8'hFF, 1'b1, CHK_MODEL,  1'b0, 31'd0},
        // length register at 0 behaves as length 1
        '{ROW_CFG,  OP_LOAD,  5'd0,  8'd0,  8'd0,  31'd0,     8'h00, 1'b0, CHK_MODEL,  1'b0, 31'd0},
        '{ROW_ITEM, OP_START, 5'd0,  8'h00, 8'h00, 31'd0,     8'h00, 1'b0, CHK_MODEL,  1'b0, 31'd0},
        '{ROW_ITEM, OP_TEXT,  5'd0,  8'h00, 8'h00, 31'd0,     LC_A,  1'b1, CHK_MODEL,  1'b0, 31'd0}
    };

    // Register setting of each random phase; length extremes 0, 1, 32 and 63
    int   mode_len  [NUM_PHASES] = '{1, 32, 0, 63, 2, 4, 3, 17};
    logic mode_fold [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    smf_req_if req_ch ();
    smf_rsp_if rsp_ch ();

    case_folding_substring_matcher_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: pattern stores, text window (index 0 newest),
    // byte counter, search state and the two registers.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] pat_lo  [PAT_MAX];
    logic [BYTE_W-1:0] pat_hi  [PAT_MAX];
    logic [BYTE_W-1:0] win     [PAT_MAX];
    logic [POS_W-1:0]  seen_cnt;
    logic [POS_W-1:0]  min_off;
    logic              idle_st;
    logic [LEN_W-1:0]  cfg_len;
    logic              cfg_fold;

    smf_res_t pending_hits [$];   // results still owed by the block
    chk_t     cur_chk;            // how the request on the bus is to be checked
    int       mismatches;
    int       fed;                // requests offered so far, spare codes aside
    int       idle_cycles;
    bit       hold_req;           // asks the result side for a long hold-off
    bit       src_calm;           // request side sends with no gaps
    bit       sink_calm;          // result side takes with no stalls

    // Length register as the block applies it: 0 acts as 1, above the store depth clamps
    function automatic int eff_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > PAT_MAX)
            return PAT_MAX;
        return int'(cfg_len);
    endfunction

    // Advance the predictor by one accepted request; hit tells whether it yields a result
    function automatic void match_step(input req_t it, output bit hit, output smf_res_t res);
        int   len;
        bit   ok;
        logic [BYTE_W-1:0] t;
        hit = 1'b0;
        res = '0;
        case (it.op)
            OP_LOAD:
            begin
                pat_lo[it.idx] = it.lo;
                pat_hi[it.idx] = it.up;
            end
            OP_START:
            begin
                min_off  = it.spos;
                seen_cnt = '0;
                foreach (win[i])
                    win[i] = '0;
                idle_st = 1'b0;
            end
            OP_TEXT:
            begin
                if (!idle_st)
                begin
                    len = eff_len();
                    for (int i = PAT_MAX - 1; i > 0; i--)
                        win[i] = win[i-1];
                    win[0] = it.txt;
                    // a saturated counter still shifts the window but checks nothing
                    if (seen_cnt != COUNT_MAX)
                    begin
                        seen_cnt = seen_cnt + 1'b1;
                        if (seen_cnt >= len && (seen_cnt - len) >= min_off)
                        begin
                            ok = 1'b1;
                            for (int i = 0; i < len; i++)
                            begin
                                t = win[len-1-i];
                                if (!(t == pat_lo[i] || (cfg_fold && t == pat_hi[i])))
                                    ok = 1'b0;
                            end
                            if (ok)
                            begin
                                idle_st       = 1'b1;
                                hit           = 1'b1;
                                res.found     = 1'b1;
                                res.match_pos = seen_cnt - POS_W'(len);
                            end
                        end
                    end
                    if (!hit && it.fin)
                    begin
                        idle_st = 1'b1;
                        hit     = 1'b1;
                    end
                end
            end
            default: ;  // unused code: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: compare results, then track register writes and requests.
    // Everything is sampled at the rising edge; inputs move on the falling one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        smf_res_t got;
        smf_res_t want;
        smf_res_t calc;
        req_t     seen_req;
        bit       hit;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.found     = rsp_ch.found;
                got.match_pos = rsp_ch.match_pos;
                if (pending_hits.size() == 0)
                begin
                    $error("result with none expected: found %0d match_pos %0d",
                           got.found, got.match_pos);
                    mismatches++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        mismatches++;
                    end
                    if (got.match_pos !== want.match_pos)
                    begin
                        $error("match_pos: expected %0d, got %0d",
                               want.match_pos, got.match_pos);
                        mismatches++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LENGTH:      cfg_len  = cfg_wdata[LEN_W-1:0];
                    CFG_IGNORE_CASE: cfg_fold = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.op   = req_ch.op;
                seen_req.idx  = req_ch.pattern_index;
                seen_req.lo   = req_ch.lower_byte;
                seen_req.up   = req_ch.upper_byte;
                seen_req.spos = req_ch.start_pos;
                seen_req.txt  = req_ch.text_byte;
                seen_req.fin  = req_ch.last_byte;
                // predictor always runs so its state stays in step with typed rows
                match_step(seen_req, hit, calc);
                case (cur_chk.mode)
                    CHK_MODEL:  if (hit) pending_hits.push_back(calc);
                    CHK_RESULT: pending_hits.push_back(cur_chk.res);
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_case_folding_substring_matcher_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Result side: a random stall before each transaction,
    // calm stretches with none, and one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        int served;
        served       = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off, counted here, while the request side keeps sending
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = sink_calm ? 0 : $urandom_range(0, 7);
                if (stall != 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if ((rsp_ch.valid && rsp_ch.ready) || hold_req)
                    break;
            end
            served++;
            if (served % 40 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request after a random gap and wait for its transaction
    task automatic send_req(input req_t it, input chk_t chk);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= it.op;
        req_ch.pattern_index <= it.idx;
        req_ch.lower_byte    <= it.lo;
        req_ch.upper_byte    <= it.up;
        req_ch.start_pos     <= it.spos;
        req_ch.text_byte     <= it.txt;
        req_ch.last_byte     <= it.fin;
        cur_chk              <= chk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (it.op != OP_SPARE)
            fed++;
        @(negedge clk);
    endtask

    // Let the block empty: every owed result in, then its pipeline flushed
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic [LEN_W-1:0] len, input logic fold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LENGTH;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_index <= CFG_IGNORE_CASE;
        cfg_wdata <= CFG_W'(fold);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly a few letters so that random text hits now and then
    function automatic logic [BYTE_W-1:0] pick_pat_byte();
        if ($urandom_range(0, 4) != 0)
            return LC_A + BYTE_W'($urandom_range(0, 2));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic req_t load_req(input logic [4:0] idx);
        req_t it;
        it     = '0;
        it.op  = OP_LOAD;
        it.idx = idx;
        it.lo  = pick_pat_byte();
        // upper byte: the case partner of a letter, or anything at all
        it.up  = ($urandom_range(0, 4) != 0) ? (it.lo ^ 8'h20) : BYTE_W'($urandom);
        return it;
    endfunction

    function automatic req_t start_req(input logic [POS_W-1:0] spos);
        req_t it;
        it      = '0;
        it.op   = OP_START;
        it.spos = spos;
        return it;
    endfunction

    function automatic req_t text_req(input logic [BYTE_W-1:0] txt, input logic fin);
        req_t it;
        it     = '0;
        it.op  = OP_TEXT;
        it.txt = txt;
        it.fin = fin;
        return it;
    endfunction

    // One search: start, then text that often carries a copy of the pattern,
    // with the odd spare code, mid-search load, early end or missing end.
    task automatic run_search();
        req_t it;
        int   len;
        int   n;
        int   at;
        int   j;
        bit   ends;
        logic [BYTE_W-1:0] b;
        logic fin;
        len      = eff_len();
        src_calm = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0:       it = start_req(POS_W'($urandom));  // mostly far out: not found
            1, 2:    it = start_req(POS_W'($urandom_range(0, 40)));
            default: it = start_req(POS_W'($urandom_range(0, 3)));
        endcase
        send_req(it, BY_MODEL);
        n    = $urandom_range(1, len + 16);
        at   = (n >= len && $urandom_range(0, 9) < 6) ? $urandom_range(0, n - len) : -1;
        ends = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                it      = '0;
                it.op   = OP_SPARE;
                it.idx  = 5'($urandom);
                it.lo   = BYTE_W'($urandom);
                it.up   = BYTE_W'($urandom);
                it.spos = POS_W'($urandom);
                it.txt  = BYTE_W'($urandom);
                it.fin  = 1'($urandom);
                send_req(it, BY_MODEL);
            end
            if ($urandom_range(0, 59) == 0)
                send_req(load_req(5'($urandom)), BY_MODEL);
            if (at >= 0 && k >= at && k < at + len)
            begin
                // embedded copy; upper bytes mostly only when folding is on
                j = k - at;
                b = (cfg_fold || $urandom_range(0, 7) == 0) && $urandom_range(0, 1) ?
                    pat_hi[j] : pat_lo[j];
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                j = $urandom_range(0, len - 1);
                b = $urandom_range(0, 1) ? pat_hi[j] : pat_lo[j];
            end
            else
                b = BYTE_W'($urandom);
            fin = (ends && k == n - 1) || ($urandom_range(0, 49) == 0);
            send_req(text_req(b, fin), BY_MODEL);
        end
        // stray byte after the end: dropped while idle
        if ($urandom_range(0, 4) == 0)
            send_req(text_req(BYTE_W'($urandom), 1'($urandom)), BY_MODEL);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        req_t it;
        chk_t chk;
        int   rand_base;

        cfg_we               = 1'b0;
        cfg_index            = CFG_LENGTH;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.op            = OP_LOAD;
        req_ch.pattern_index = '0;
        req_ch.lower_byte    = '0;
        req_ch.upper_byte    = '0;
        req_ch.start_pos     = '0;
        req_ch.text_byte     = '0;
        req_ch.last_byte     = 1'b0;
        cur_chk              = BY_MODEL;
        mismatches           = 0;
        fed                  = 0;
        hold_req             = 1'b0;
        src_calm             = 1'b0;

        // predictor reset state: store contents unknown until loaded
        foreach (win[i])
            win[i] = '0;
        seen_cnt = '0;
        min_off  = '0;
        idle_st  = 1'b1;
        cfg_len  = LEN_W'(1);
        cfg_fold = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                settle();
                set_mode(dir_rows[r].lo[LEN_W-1:0], dir_rows[r].up[0]);
            end
            else
            begin
                it.op             = dir_rows[r].op;
                it.idx            = dir_rows[r].idx;
                it.lo             = dir_rows[r].lo;
                it.up             = dir_rows[r].up;
                it.spos           = dir_rows[r].spos;
                it.txt            = dir_rows[r].txt;
                it.fin            = dir_rows[r].fin;
                chk.mode          = dir_rows[r].mode;
                chk.res.found     = dir_rows[r].found;
                chk.res.match_pos = dir_rows[r].pos;
                send_req(it, chk);
            end
        end

        // Random phases, each under its own register setting
        rand_base = fed;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // the request side pauses here until every owed result is in
            settle();
            set_mode(LEN_W'(mode_len[p]), mode_fold[p]);
            if (p == 0)
            begin
                // fill the whole store so no search ever reads an unloaded entry
                for (int i = 0; i < PAT_MAX; i++)
                    send_req(load_req(5'(i)), BY_MODEL);
                // one-byte searches back to back against a held result side:
                // the result queue fills and the request side must stall
                hold_req = 1'b1;
                src_calm = 1'b1;
                repeat (16)
                begin
                    send_req(start_req('0), BY_MODEL);
                    send_req(text_req(pat_lo[0] ^ BYTE_W'($urandom_range(0, 1)), 1'b1),
                             BY_MODEL);
                end
            end
            while (fed - rand_base < ITEMS * (p + 1) / NUM_PHASES)
                run_search();
        end

        settle();
        if (mismatches == 0)
            $display("tb_case_folding_substring_matcher_top OK");
        else
            $display("tb_case_folding_substring_matcher_top NOT OK");
        $finish;
    end

endmodule
